>>> design/utcgw_pkg.sv
// Shared types, constants and helper functions for the UTC date/time to GPS week block.
// No dependencies; every other design file imports this package.
package utcgw_pkg;

    localparam int NUM_W      = 30;                // packed decimal input value
    localparam int WEEK_W     = 13;
    localparam int TOW_W      = 31;
    localparam int FIELD_W    = 7;                 // two-digit decimal field
    localparam int REM_W      = 10;                // remainder of the largest divisor
    localparam int MAX_MONTH_STEPS_DEF = 1200;

    // rounded-up reciprocals: quotient = (x * recip) >> shift, exact for any 30-bit x
    localparam int RECIP_W    = 31;
    localparam int PROD_W     = NUM_W + RECIP_W;
    localparam int SHIFT_7    = 33;
    localparam int SHIFT_100  = 37;
    localparam int SHIFT_1000 = 40;

    localparam logic [WEEK_W-1:0] GPS_WEEK_BASE = 13'd1634;
    localparam logic signed [27:0] MS_IN_DAY    = 28'sd86400000;
    localparam logic [3:0]  START_MONTH = 4'd5;
    localparam logic [7:0]  START_YEAR  = 8'd11;

    typedef enum logic [1:0] {
        DIV_BY_7,
        DIV_BY_100,
        DIV_BY_1000
    } t_div_sel;

    // Horner steps for the time of week
    typedef enum logic [1:0] {
        MAC_MIN,
        MAC_SEC,
        MAC_MS,
        MAC_DAY
    } t_mac_step;

    typedef struct packed {
        logic      load;
        logic      div_mul;
        t_div_sel  div_sel;
        logic      field_wr;
        logic [1:0] field_idx;
        logic      zero_res;
        logic      walk_init;
        logic      walk_step;
        logic      day_load;
        logic      date_fin;
        logic      mac_step;
        t_mac_step mac_idx;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic date_zero;
        logic walk_more;
        logic out_free;
    } t_dp_sts;

    function automatic logic [REM_W-1:0] divisor(input t_div_sel sel);
        logic [REM_W-1:0] d;
        unique case (sel)
            DIV_BY_7:    d = 10'd7;
            DIV_BY_100:  d = 10'd100;
            DIV_BY_1000: d = 10'd1000;
            default:     d = 10'd100;
        endcase
        return d;
    endfunction

    function automatic logic [RECIP_W-1:0] recip(input t_div_sel sel);
        logic [RECIP_W-1:0] m;
        unique case (sel)
            DIV_BY_7:    m = 31'd1227133514;
            DIV_BY_100:  m = 31'd1374389535;
            DIV_BY_1000: m = 31'd1099511628;
            default:     m = 31'd1374389535;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> design/utcgw_ifs.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on utcgw_pkg for the field widths.
interface utcgw_in_if import utcgw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [NUM_W-1:0] packed_value;

    modport source (output valid, output op, output packed_value, input ready);
    modport sink   (input valid, input op, input packed_value, output ready);
endinterface

interface utcgw_out_if import utcgw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [WEEK_W-1:0]        week_number;
    logic signed [TOW_W-1:0]  time_of_week_ms;

    modport source (output valid, output week_number, output time_of_week_ms, input ready);
    modport sink   (input valid, input week_number, input time_of_week_ms, output ready);
endinterface

>>> design/utcgw_ctrl.sv
// Sequencer: steps the reciprocal divider, the month walk and the multiply-add chain.
// Depends on utcgw_pkg; drives the datapath through t_dp_cmd only.
module utcgw_ctrl import utcgw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIVM = 9'b000000010,
        ST_DIVF = 9'b000000100,
        ST_PREP = 9'b000001000,
        ST_WALK = 9'b000010000,
        ST_D7M  = 9'b000100000,
        ST_D7F  = 9'b001000000,
        ST_MAC  = 9'b010000000,
        ST_DONE = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [1:0]          r_fidx, n_fidx;
    t_mac_step           r_mac, n_mac;

    logic field_last;
    logic ms_field;

    assign field_last = i_sts.op ? (r_fidx == 2'd3) : (r_fidx == 2'd2);
    // milliseconds take three digits, every other field two
    assign ms_field   = i_sts.op && (r_fidx == 2'd0);
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_fidx   = r_fidx;
        n_mac    = r_mac;
        o_cmd    = '0;
        o_cmd.div_sel   = DIV_BY_100;
        o_cmd.field_idx = r_fidx;
        o_cmd.mac_idx   = r_mac;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_fidx     = '0;
                    n_state    = ST_DIVM;
                end
            end
            ST_DIVM: begin
                o_cmd.div_mul = 1'b1;
                o_cmd.div_sel = ms_field ? DIV_BY_1000 : DIV_BY_100;
                n_state       = ST_DIVF;
            end
            ST_DIVF: begin
                o_cmd.div_sel  = ms_field ? DIV_BY_1000 : DIV_BY_100;
                o_cmd.field_wr = 1'b1;
                n_fidx         = r_fidx + 1'b1;
                if (field_last) begin
                    n_state = ST_PREP;
                end else begin
                    n_state = ST_DIVM;
                end
            end
            ST_PREP: begin
                if (i_sts.op) begin
                    n_mac   = MAC_MIN;
                    n_state = ST_MAC;
                end else if (i_sts.date_zero) begin
                    o_cmd.zero_res = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_sts.walk_more) begin
                    o_cmd.walk_step = 1'b1;
                end else begin
                    o_cmd.day_load = 1'b1;
                    n_state        = ST_D7M;
                end
            end
            ST_D7M: begin
                o_cmd.div_mul = 1'b1;
                o_cmd.div_sel = DIV_BY_7;
                n_state       = ST_D7F;
            end
            ST_D7F: begin
                o_cmd.div_sel  = DIV_BY_7;
                o_cmd.date_fin = 1'b1;
                n_state        = ST_DONE;
            end
            ST_MAC: begin
                o_cmd.mac_step = 1'b1;
                n_mac          = t_mac_step'(r_mac + 2'd1);
                if (r_mac == MAC_DAY) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fidx   <= '0;
            r_mac    <= MAC_MIN;
        end else begin
            r_state  <= n_state;
            r_fidx   <= n_fidx;
            r_mac    <= n_mac;
        end
    end

endmodule

>>> design/utcgw_dp.sv
// Datapath: reciprocal-multiply constant divider, month walk, multiply-add and output register.
// Depends on utcgw_pkg; controlled by utcgw_ctrl through t_dp_cmd / t_dp_sts.
module utcgw_dp import utcgw_pkg::*; #(
    parameter int MAX_MONTH_STEPS = MAX_MONTH_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic                    i_op,
    input  logic [NUM_W-1:0]        i_packed_value,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [WEEK_W-1:0]       o_week_number,
    output logic signed [TOW_W-1:0] o_time_of_week_ms
);

    localparam int STEP_W = $clog2(MAX_MONTH_STEPS + 2);
    localparam int DAY_W  = $clog2((MAX_MONTH_STEPS + 1) * 32 + 100);

    logic                r_op;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_quo;
    logic [REM_W-1:0]    r_f0;          // year or milliseconds
    logic [FIELD_W-1:0]  r_f1;          // month or seconds
    logic [FIELD_W-1:0]  r_f2;          // day or minutes
    logic [FIELD_W-1:0]  r_f3;          // hours
    logic [DAY_W-1:0]    r_day;
    logic [3:0]          r_m;
    logic [7:0]          r_y;
    logic [STEP_W-1:0]   r_steps;
    logic [31:0]         r_acc;
    logic signed [3:0]   r_wd;
    logic [WEEK_W-1:0]   r_res_week;
    logic [TOW_W-1:0]    r_res_tow;
    logic                r_out_valid;
    logic [WEEK_W-1:0]   r_out_week;
    logic [TOW_W-1:0]    r_out_tow;

    // divider: quotient estimate is registered, then the remainder comes from the registered quotient
    logic [RECIP_W-1:0]  div_m;
    logic [PROD_W-1:0]   div_prod;
    logic [NUM_W-1:0]    quo_est;
    logic [REM_W-1:0]    div_d;
    logic [NUM_W-1:0]    quo_x_d;
    logic [NUM_W-1:0]    rem_full;
    logic [REM_W-1:0]    n_rem;

    assign div_m    = recip(i_cmd.div_sel);
    assign div_d    = divisor(i_cmd.div_sel);
    assign div_prod = r_num * div_m;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_BY_7:    quo_est = NUM_W'(div_prod[PROD_W-1:SHIFT_7]);
            DIV_BY_1000: quo_est = NUM_W'(div_prod[PROD_W-1:SHIFT_1000]);
            default:     quo_est = NUM_W'(div_prod[PROD_W-1:SHIFT_100]);
        endcase
    end

    assign quo_x_d  = r_quo * NUM_W'(div_d);
    assign rem_full = r_num - quo_x_d;
    assign n_rem    = rem_full[REM_W-1:0];

    // month walk
    logic       leap;
    logic [4:0] add_days;
    assign leap = (r_m == 4'd2) && (r_y[1:0] == 2'b00)
                  && (r_y != 8'd0) && (r_y != 8'd100) && (r_y != 8'd200);
    assign add_days = month_len(r_m) + {4'd0, leap};

    assign o_sts.op        = r_op;
    assign o_sts.date_zero = (r_f1 == '0) || (r_f2 == '0);
    assign o_sts.walk_more = (({4'd0, r_m} < {1'b0, r_f1}) || (r_y < {1'b0, r_f0[FIELD_W-1:0]}))
                             && (r_steps <= STEP_W'(MAX_MONTH_STEPS));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // multiply-add for the time of week
    logic [31:0]        mul_a;
    logic [27:0]        mul_k;
    logic [31:0]        add_b;
    logic signed [59:0] prod;
    logic [31:0]        n_acc;

    always_comb begin
        case (i_cmd.mac_idx)
            MAC_MIN: begin
                mul_a = 32'(r_f3);
                mul_k = 28'd60;
                add_b = 32'(r_f2);
            end
            MAC_SEC: begin
                mul_a = r_acc;
                mul_k = 28'd60;
                add_b = 32'(r_f1);
            end
            MAC_MS: begin
                mul_a = r_acc;
                mul_k = 28'd1000;
                add_b = 32'(r_f0);
            end
            default: begin
                mul_a = {{28{r_wd[3]}}, r_wd};
                mul_k = MS_IN_DAY;
                add_b = r_acc;
            end
        endcase
    end

    assign prod  = $signed(mul_a) * $signed(mul_k);
    assign n_acc = prod[31:0] + add_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_num <= i_packed_value;
        end else if (i_cmd.day_load) begin
            r_num <= NUM_W'(r_day);
        end else if (i_cmd.field_wr) begin
            // advance to the remaining upper digits
            r_num <= r_quo;
        end

        if (i_cmd.div_mul) begin
            r_quo <= quo_est;
        end

        if (i_cmd.field_wr) begin
            case (i_cmd.field_idx)
                2'd0:    r_f0 <= n_rem;
                2'd1:    r_f1 <= n_rem[FIELD_W-1:0];
                2'd2:    r_f2 <= n_rem[FIELD_W-1:0];
                default: r_f3 <= n_rem[FIELD_W-1:0];
            endcase
        end

        if (i_cmd.walk_init) begin
            r_day   <= DAY_W'(r_f2);
            r_m     <= START_MONTH;
            r_y     <= START_YEAR;
            r_steps <= '0;
        end else if (i_cmd.walk_step) begin
            r_day   <= r_day + DAY_W'(add_days);
            r_steps <= r_steps + 1'b1;
            if (r_m == 4'd12) begin
                r_m <= 4'd1;
                r_y <= r_y + 8'd1;
            end else begin
                r_m <= r_m + 4'd1;
            end
        end

        if (i_cmd.mac_step) begin
            r_acc <= n_acc;
        end

        if (i_cmd.zero_res) begin
            r_res_week <= '0;
            r_res_tow  <= '0;
        end else if (i_cmd.date_fin) begin
            r_res_week <= GPS_WEEK_BASE + r_quo[WEEK_W-1:0];
            r_res_tow  <= '0;
        end else if (i_cmd.mac_step && i_cmd.mac_idx == MAC_DAY) begin
            r_res_week <= '0;
            r_res_tow  <= n_acc[TOW_W-1:0];
        end

        if (i_cmd.out_load) begin
            r_out_week <= r_res_week;
            r_out_tow  <= r_res_tow;
        end
    end

    // control state: weekday offset and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.date_fin) begin
                r_wd <= $signed({1'b0, n_rem[2:0]}) - 4'sd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_week_number     = r_out_week;
    assign o_time_of_week_ms = $signed(r_out_tow);

endmodule

>>> design/utc_date_time_to_gps_week.sv
// Top level: GPS week number from a DDMMYY date, time of week from HHMMSSmmm.
// Depends on utcgw_pkg, utcgw_ifs, utcgw_ctrl and utcgw_dp.
//
//  Channel    Dir  Payload                              Handshake
//  i_in_ch    in   op, packed_value[29:0]               valid/ready
//  o_out_ch   out  week_number[12:0], time_of_week_ms   valid/ready
//
// Each decimal field passes through the reciprocal divider as a quotient, then a
// remainder. A date op walks at most MAX_MONTH_STEPS + 1 months, advancing one month
// per cycle; a zero day or month skips the walk.
// One item is in work at a time; the output register lets the next item enter
// while a result waits. Reset is synchronous, active low, and clears the weekday.
module utc_date_time_to_gps_week import utcgw_pkg::*; #(
    parameter int MAX_MONTH_STEPS = MAX_MONTH_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utcgw_in_if.sink     i_in_ch,
    utcgw_out_if.source  o_out_ch
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    utcgw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (i_in_ch.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    utcgw_dp #(
        .MAX_MONTH_STEPS (MAX_MONTH_STEPS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_op              (i_in_ch.op),
        .i_packed_value    (i_in_ch.packed_value),
        .i_out_ready       (o_out_ch.ready),
        .o_out_valid       (o_out_ch.valid),
        .o_week_number     (o_out_ch.week_number),
        .o_time_of_week_ms (o_out_ch.time_of_week_ms)
    );

endmodule

>>> design/utcgw_chk.sv
// Port-level checks for utc_date_time_to_gps_week, bound to the top level.
// Depends on utcgw_pkg for field widths.
module utcgw_chk import utcgw_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [WEEK_W-1:0]       i_week_number,
    input logic signed [TOW_W-1:0] i_time_of_week_ms
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one transaction in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    // a date result never carries a time of week
    a_date_no_tow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_week_number != '0 |-> i_time_of_week_ms == '0)
        else $error("week and time of week both set");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_week_number)
            && $stable(i_time_of_week_ms))
        else $error("stalled result changed");

endmodule

bind utc_date_time_to_gps_week utcgw_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_ch.valid),
    .i_in_ready        (i_in_ch.ready),
    .i_out_valid       (o_out_ch.valid),
    .i_out_ready       (o_out_ch.ready),
    .i_week_number     (o_out_ch.week_number),
    .i_time_of_week_ms (o_out_ch.time_of_week_ms)
);

>>> test/tb_top.sv
// Self-checking bench for utc_date_time_to_gps_week: directed table, then random dates and times.
// Depends on utcgw_pkg, the utcgw channel interfaces and the design sources under design/.
module tb_top;
    import utcgw_pkg::*;

    localparam int          DIRECTED_N   = 22;
    localparam int          RANDOM_N     = 438;
    localparam int          HOLD_CYCLES  = 3000;
    localparam int          DRAIN_CYCLES = 1400;
    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam int unsigned WALK_LIMIT   = 1200;
    localparam int unsigned GPS_WEEK_START = 1634;
    localparam longint      DAY_MS       = 86400000;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    localparam logic OP_DATE = 1'b0;
    localparam logic OP_TIME = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [NUM_W-1:0]         value;
        logic                     typed;
        logic [WEEK_W-1:0]        week;
        logic signed [TOW_W-1:0]  tow;
    } t_stim_row;

    typedef struct packed {
        logic [WEEK_W-1:0]        week;
        logic signed [TOW_W-1:0]  tow;
    } t_gps_result;

    // Results read straight off the calendar are typed in; the rest go to the predictor.
    t_stim_row directed_rows [DIRECTED_N] = '{
        '{OP_TIME, 30'd0,         1'b1, 13'd0,    31'sd0},         // time right after reset
        '{OP_DATE, 30'd10511,     1'b1, 13'd1634, 31'sd0},         // 1 May 2011
        '{OP_TIME, 30'd0,         1'b1, 13'd0,    31'sd0},
        '{OP_DATE, 30'd70511,     1'b1, 13'd1635, 31'sd0},         // day count 0 mod 7
        '{OP_TIME, 30'd0,         1'b1, 13'd0,    -31'sd86400000}, // weekday kept as -1
        '{OP_DATE, 30'd511,       1'b1, 13'd0,    31'sd0},         // zero day
        '{OP_TIME, 30'd0,         1'b1, 13'd0,    -31'sd86400000}, // weekday unchanged
        '{OP_DATE, 30'd10011,     1'b1, 13'd0,    31'sd0},         // zero month
        '{OP_DATE, 30'd60511,     1'b1, 13'd1634, 31'sd0},         // largest weekday
        '{OP_TIME, 30'd999999999, 1'b0, 13'd0,    31'sd0},
        '{OP_TIME, 30'h3FFFFFFF,  1'b0, 13'd0,    31'sd0},
        '{OP_DATE, 30'd311299,    1'b0, 13'd0,    31'sd0},
        '{OP_DATE, 30'd999999,    1'b0, 13'd0,    31'sd0},         // month 99, walk capped
        '{OP_DATE, 30'd10510,     1'b0, 13'd0,    31'sd0},         // year before start
        '{OP_DATE, 30'h3FFFFFFF,  1'b0, 13'd0,    31'sd0},
        '{OP_DATE, 30'd290212,    1'b0, 13'd0,    31'sd0},         // leap day
        '{OP_TIME, 30'd235959999, 1'b0, 13'd0,    31'sd0},
        '{OP_DATE, 30'd10300,     1'b0, 13'd0,    31'sd0},         // year 00, no walk
        '{OP_TIME, 30'd606060999, 1'b0, 13'd0,    31'sd0},         // digits out of range
        '{OP_DATE, 30'd150124,    1'b0, 13'd0,    31'sd0},
        '{OP_TIME, 30'd0,         1'b0, 13'd0,    31'sd0},
        '{OP_DATE, 30'd0,         1'b1, 13'd0,    31'sd0}          // all zero
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    utcgw_in_if  in_ch ();
    utcgw_out_if out_ch ();

    utc_date_time_to_gps_week dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic signed [3:0] weekday_now;
    t_gps_result       pending_results [$];

    // current row's typed result, valid while in_ch.valid is high
    logic                    row_typed;
    logic [WEEK_W-1:0]       row_week;
    logic signed [TOW_W-1:0] row_tow;

    int          err_count;
    int          n_date, n_time, n_zero_date, n_results;
    int unsigned cycle_count;
    bit          calm;
    bit          hold_request;
    bit          hold_taken;

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic logic [WEEK_W-1:0] gps_week_of_date(input logic [NUM_W-1:0] v);
        int unsigned yy, mm, dd, m, y, steps;
        yy = v % 100;
        mm = (v / 100) % 100;
        dd = (v / 10000) % 100;
        if (dd == 0 || mm == 0)
            return '0;
        m = 5;
        y = 11;
        steps = 0;
        while (m < mm || y < yy) begin
            dd += MONTH_DAYS[m - 1];
            if (m == 2 && (y % 4) == 0 && (y % 100) != 0)
                dd += 1;
            m++;
            if (m == 13) begin
                m = 1;
                y = (y + 1) & 8'hFF;
            end
            steps++;
            if (steps > WALK_LIMIT)
                break;
        end
        weekday_now = 4'(int'(dd % 7) - 1);
        return WEEK_W'(GPS_WEEK_START + dd / 7);
    endfunction

    function automatic logic signed [TOW_W-1:0] tow_of_clock(input logic [NUM_W-1:0] v);
        longint t;
        t = ((longint'((v / 10000000) % 100) * 60 + longint'((v / 100000) % 100)) * 60
             + longint'((v / 1000) % 100)) * 1000 + longint'(v % 1000);
        t += longint'(weekday_now) * DAY_MS;
        return t[TOW_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("** utc_date_time_to_gps_week: FAILED **");
            $finish;
        end
    end

    // Check results first, then predict the transaction accepted at this edge.
    always @(posedge i_clk) begin : scoreboard
        t_gps_result want, got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                got.week = out_ch.week_number;
                got.tow  = out_ch.time_of_week_ms;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result week=%0d tow=%0d with nothing expected",
                                              got.week, got.tow));
                end else begin
                    want = pending_results.pop_front();
                    if (got.week !== want.week)
                        report_mismatch($sformatf("week_number %0d, expected %0d",
                                                  got.week, want.week));
                    if (got.tow !== want.tow)
                        report_mismatch($sformatf("time_of_week_ms %0d, expected %0d",
                                                  got.tow, want.tow));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.op == OP_DATE) begin
                    n_date++;
                    if ((in_ch.packed_value / 10000) % 100 == 0
                        || (in_ch.packed_value / 100) % 100 == 0)
                        n_zero_date++;
                    want.week = gps_week_of_date(in_ch.packed_value);
                    want.tow  = '0;
                end else begin
                    n_time++;
                    want.week = '0;
                    want.tow  = tow_of_clock(in_ch.packed_value);
                end
                if (row_typed) begin
                    want.week = row_week;
                    want.tow  = row_tow;
                end
                pending_results.push_back(want);
            end
        end
    end

    // Result side: random back-pressure, one long hold-off on request.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_item(input logic op, input logic [NUM_W-1:0] value, input logic typed,
                              input logic [WEEK_W-1:0] week, input logic signed [TOW_W-1:0] tow);
        while (!calm && $urandom_range(99) < 6) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.packed_value <= value;
        row_typed          <= typed;
        row_week           <= week;
        row_tow            <= tow;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic              op;
        logic [NUM_W-1:0]  value;
        int unsigned       pick;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = 1'b0;
        in_ch.packed_value = '0;
        row_typed          = 1'b0;
        row_week           = '0;
        row_tow            = '0;
        weekday_now        = '0;
        err_count = 0; n_date = 0; n_time = 0; n_zero_date = 0; n_results = 0;
        cycle_count = 0; calm = 1'b0; hold_request = 1'b0; hold_taken = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            offer_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                       directed_rows[i].week, directed_rows[i].tow);

        for (int i = 0; i < RANDOM_N; i++) begin
            if (i == 80)
                hold_request = 1'b1;    // keep offering while the receiver is held off
            if (i == 220) begin
                // drain fully before going on
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
                while (pending_results.size() > 0) @(negedge i_clk);
            end
            calm = (i >= 300 && i < 370);
            op   = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (op == OP_DATE) begin
                if (pick < 70)
                    value = NUM_W'($urandom_range(31, 1) * 10000 + $urandom_range(12, 1) * 100
                                   + $urandom_range(60, 11));
                else if (pick < 76)
                    value = NUM_W'($urandom_range(31, 1) * 10000 + $urandom_range(12, 1) * 100
                                   + $urandom_range(99));
                else if (pick < 84)
                    value = NUM_W'(($urandom_range(1) ? 0 : $urandom_range(99)) * 10000
                                   + $urandom_range(1) * $urandom_range(12) * 100
                                   + $urandom_range(99));
                else
                    value = NUM_W'($urandom() & 32'h3FFF_FFFF);
            end else begin
                if (pick < 70)
                    value = NUM_W'($urandom_range(23) * 10000000 + $urandom_range(59) * 100000
                                   + $urandom_range(59) * 1000 + $urandom_range(999));
                else
                    value = NUM_W'($urandom() & 32'h3FFF_FFFF);
            end
            offer_item(op, value, 1'b0, '0, '0);
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;
        row_typed   <= 1'b0;

        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d date items (%0d with zero day or month) and %0d time items,",
                 n_date, n_zero_date, n_time);
        $display("%0d results checked, one long result hold-off and one full drain pause",
                 n_results);
        if (err_count == 0) begin
            $display("** utc_date_time_to_gps_week: PASSED **");
        end else begin
            $display("%0d mismatches", err_count);
            $display("** utc_date_time_to_gps_week: FAILED **");
        end
        $finish;
    end

endmodule
